// ----- hdl/shlae_pkg.sv -----
// shared types and constants for the spherical-harmonic light accumulator
package shlae_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int DIR_W      = 16;
    localparam int COLOR_W    = 16;
    localparam int OUT_W      = 32;
    localparam int N_CHAN     = 3;
    localparam int N_TERMS    = 9;
    localparam int IDX_W      = $clog2(N_TERMS);

    localparam logic [IDX_W-1:0] TERM_LAST = IDX_W'(N_TERMS - 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_SAMPLE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic             load;
        logic             clear;
        logic             issue;
        logic [IDX_W-1:0] idx;
        logic             sample;
        logic             out_load;
    } t_ctl;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/shlae_ctrl.sv -----
// sequencer: accepts requests, steps through the nine basis terms, releases results
module shlae_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [1:0]                 i_cmd,
    output logic                       o_in_stall,
    input  shlae_pkg::t_sts            i_sts,
    output shlae_pkg::t_ctl            o_ctl
);
    import shlae_pkg::*;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_sample, n_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_sample <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sample <= n_sample;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_sample       = r_sample;
        o_ctl          = '0;
        o_ctl.idx      = r_cnt;
        o_ctl.sample   = r_sample;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    case (i_cmd)
                        CMD_CLEAR: begin
                            o_ctl.clear = 1'b1;
                        end
                        CMD_ADD, CMD_SAMPLE: begin
                            n_state  = ST_ISSUE;
                            n_cnt    = '0;
                            n_sample = (i_cmd == CMD_SAMPLE);
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                o_ctl.issue = 1'b1;
                if (r_cnt == TERM_LAST) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    if (!r_sample) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.out_free) begin
                        o_ctl.out_load = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ----- hdl/shlae_dp.sv -----
// datapath: basis factors, per-channel multipliers, coefficient store and output register
module shlae_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [shlae_pkg::COLOR_W-1:0]     i_color_r,
    input  logic [shlae_pkg::COLOR_W-1:0]     i_color_g,
    input  logic [shlae_pkg::COLOR_W-1:0]     i_color_b,
    input  logic signed [shlae_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [shlae_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [shlae_pkg::DIR_W-1:0] i_dir_z,
    input  shlae_pkg::t_ctl                   i_ctl,
    output shlae_pkg::t_sts                   o_sts,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [shlae_pkg::OUT_W-1:0] o_out_r,
    output logic signed [shlae_pkg::OUT_W-1:0] o_out_g,
    output logic signed [shlae_pkg::OUT_W-1:0] o_out_b
);
    import shlae_pkg::*;

    localparam int F_W   = 33;
    localparam int CK_W  = 20;
    localparam int HI_W  = COEF_WIDTH - 16;
    localparam int MA_W  = (CK_W + 1 > HI_W) ? CK_W + 1 : HI_W;
    localparam int LO_W  = 17;
    localparam int PH_W  = MA_W + F_W;
    localparam int PL_W  = LO_W + F_W;
    localparam int P_W   = ((PH_W + 16 > PL_W) ? PH_W + 16 : PL_W) + 1;
    localparam int TW    = P_W - 28;
    localparam int S_W   = ((COEF_WIDTH > TW) ? COEF_WIDTH : TW) + 1;
    localparam int ACC_W = TW + 4;

    localparam logic signed [F_W-1:0]   F_ONE = F_W'(1) <<< 28;
    localparam logic signed [F_W:0]     F_ONE_X = (F_W + 1)'(1) <<< 28;
    localparam logic signed [P_W-1:0]   RND   = P_W'(1) <<< 27;
    localparam logic signed [S_W-1:0]   C_MAX = S_W'({1'b0, {(COEF_WIDTH-1){1'b1}}});
    localparam logic signed [S_W-1:0]   C_MIN = -C_MAX - S_W'(1);
    localparam logic signed [ACC_W-1:0] O_MAX = ACC_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] O_MIN = -O_MAX - ACC_W'(1);

    localparam logic [15:0] K_TAB [N_TERMS] = '{
        16'd15420, 16'd30840, 16'd30840, 16'd30840,
        16'd57826, 16'd57826, 16'd57826, 16'd4819, 16'd14456
    };

    // captured request
    logic signed [DIR_W-1:0]   r_x, r_y, r_z;
    logic [COLOR_W-1:0]        r_col [N_CHAN];

    // coefficient store
    logic signed [COEF_WIDTH-1:0] r_coef [N_CHAN][N_TERMS];

    // pipeline control
    logic             r_v0, r_v1, r_v2;
    logic [IDX_W-1:0] r_i1, r_i2;
    logic [IDX_W-1:0] r_i0;

    // stage registers
    logic signed [F_W-1:0]        r_f;
    logic [31:0]                  r_ckp [N_CHAN];
    logic signed [COEF_WIDTH-1:0] r_c0 [N_CHAN];
    logic signed [COEF_WIDTH-1:0] r_c1 [N_CHAN];
    logic signed [COEF_WIDTH-1:0] r_c2 [N_CHAN];
    logic signed [PH_W-1:0]       r_ph [N_CHAN];
    logic signed [PL_W-1:0]       r_pl [N_CHAN];
    logic signed [TW-1:0]         r_term [N_CHAN];
    logic signed [ACC_W-1:0]      r_acc [N_CHAN];

    logic                         r_out_valid;
    logic signed [OUT_W-1:0]      r_out [N_CHAN];

    // basis factor for the current term
    logic signed [DIR_W-1:0]   a1, b1;
    logic signed [31:0]        m1, m2;
    logic signed [F_W:0]       f7_x;
    logic signed [F_W-1:0]     f_cur;

    always_comb begin
        a1 = r_x;
        b1 = r_z;
        case (i_ctl.idx)
            IDX_W'(5): begin a1 = r_z; b1 = r_y; end
            IDX_W'(6): begin a1 = r_y; b1 = r_x; end
            IDX_W'(7): begin a1 = r_z; b1 = r_z; end
            IDX_W'(8): begin a1 = r_x; b1 = r_x; end
            default:   begin a1 = r_x; b1 = r_z; end
        endcase
    end

    assign m1   = a1 * b1;
    assign m2   = r_y * r_y;
    assign f7_x = ((F_W + 1)'(m1) <<< 1) + (F_W + 1)'(m1) - F_ONE_X;

    always_comb begin
        case (i_ctl.idx)
            IDX_W'(0): f_cur = F_ONE;
            IDX_W'(1): f_cur = {{3{r_x[DIR_W-1]}}, r_x, 14'd0};
            IDX_W'(2): f_cur = {{3{r_y[DIR_W-1]}}, r_y, 14'd0};
            IDX_W'(3): f_cur = {{3{r_z[DIR_W-1]}}, r_z, 14'd0};
            IDX_W'(4), IDX_W'(5), IDX_W'(6): f_cur = F_W'(m1);
            IDX_W'(7): f_cur = f7_x[F_W-1:0];
            IDX_W'(8): f_cur = F_W'(m1) - F_W'(m2);
            default:   f_cur = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x      <= i_dir_x;
            r_y      <= i_dir_y;
            r_z      <= i_dir_z;
            r_col[0] <= i_color_r;
            r_col[1] <= i_color_g;
            r_col[2] <= i_color_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_ctl.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i0 <= i_ctl.idx;
        r_i1 <= r_i0;
        r_i2 <= r_i1;
        r_f  <= f_cur;
    end

    for (genvar ch = 0; ch < N_CHAN; ch++) begin : g_chan
        logic [32:0]              ck_sum;
        logic [CK_W-1:0]          ck;
        logic signed [MA_W-1:0]   opa;
        logic signed [LO_W-1:0]   opl;
        logic signed [P_W-1:0]    p_sum;
        logic signed [P_W-1:0]    p_rnd;
        logic signed [S_W-1:0]    c_sum;
        logic signed [COEF_WIDTH-1:0] c_sat;
        logic signed [ACC_W-1:0]  acc_v;

        assign ck_sum = {1'b0, r_ckp[ch]} + 33'd2048;
        assign ck     = ck_sum[12 +: CK_W];

        assign opa = i_ctl.sample ? MA_W'($signed(r_c0[ch][COEF_WIDTH-1:16]))
                                  : MA_W'({1'b0, ck});
        assign opl = i_ctl.sample ? $signed({1'b0, r_c0[ch][15:0]}) : '0;

        assign p_sum = (i_ctl.sample ? (P_W'(r_ph[ch]) <<< 16) : P_W'(r_ph[ch]))
                       + P_W'(r_pl[ch]);
        assign p_rnd = p_sum + RND;

        assign c_sum = S_W'(r_c2[ch]) + S_W'(r_term[ch]);
        always_comb begin
            if (c_sum > C_MAX) begin
                c_sat = C_MAX[COEF_WIDTH-1:0];
            end else if (c_sum < C_MIN) begin
                c_sat = C_MIN[COEF_WIDTH-1:0];
            end else begin
                c_sat = c_sum[COEF_WIDTH-1:0];
            end
        end

        assign acc_v = r_acc[ch];

        // stage 0: color scale product and coefficient read
        always_ff @(posedge i_clk) begin
            r_ckp[ch] <= r_col[ch] * K_TAB[i_ctl.idx];
            r_c0[ch]  <= r_coef[ch][i_ctl.idx];
        end

        // stage 1: multiply by basis factor
        always_ff @(posedge i_clk) begin
            r_ph[ch] <= opa * r_f;
            r_pl[ch] <= opl * r_f;
            r_c1[ch] <= r_c0[ch];
        end

        // stage 2: recombine and round
        always_ff @(posedge i_clk) begin
            r_term[ch] <= p_rnd[P_W-1:28];
            r_c2[ch]   <= r_c1[ch];
        end

        // stage 3: coefficient update or evaluation sum
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_ctl.clear) begin
                for (int t = 0; t < N_TERMS; t++) begin
                    r_coef[ch][t] <= '0;
                end
            end else if (r_v2 && !i_ctl.sample) begin
                r_coef[ch][r_i2] <= c_sat;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.load) begin
                r_acc[ch] <= '0;
            end else if (r_v2 && i_ctl.sample) begin
                r_acc[ch] <= r_acc[ch] + ACC_W'(r_term[ch]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.out_load) begin
                if (acc_v > O_MAX) begin
                    r_out[ch] <= O_MAX[OUT_W-1:0];
                end else if (acc_v < O_MIN) begin
                    r_out[ch] <= O_MIN[OUT_W-1:0];
                end else begin
                    r_out[ch] <= acc_v[OUT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.busy     = r_v0 || r_v1 || r_v2;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_r     = r_out[0];
    assign o_out_g     = r_out[1];
    assign o_out_b     = r_out[2];

endmodule

// ----- hdl/sh_light_accumulate_evaluate.sv -----
// top level of the second-order spherical-harmonic light accumulator
// clear and unused requests leave the input ready; add and sample requests stall it
// until the sequencer returns to idle: nine basis terms go one per cycle through a
// four-stage multiply pipeline, one per color channel, and the sequencer then drains it
// a sample result is loaded once the output register is free and waits there until taken
// synchronous active-low reset zeroes all coefficients and empties the output
module sh_light_accumulate_evaluate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_cmd,
    input  logic [shlae_pkg::COLOR_W-1:0]      i_color_r,
    input  logic [shlae_pkg::COLOR_W-1:0]      i_color_g,
    input  logic [shlae_pkg::COLOR_W-1:0]      i_color_b,
    input  logic signed [shlae_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [shlae_pkg::DIR_W-1:0] i_dir_y,
    input  logic signed [shlae_pkg::DIR_W-1:0] i_dir_z,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [shlae_pkg::OUT_W-1:0] o_out_r,
    output logic signed [shlae_pkg::OUT_W-1:0] o_out_g,
    output logic signed [shlae_pkg::OUT_W-1:0] o_out_b
);
    import shlae_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    shlae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    shlae_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_color_r   (i_color_r),
        .i_color_g   (i_color_g),
        .i_color_b   (i_color_b),
        .i_dir_x     (i_dir_x),
        .i_dir_y     (i_dir_y),
        .i_dir_z     (i_dir_z),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_r     (o_out_r),
        .o_out_g     (o_out_g),
        .o_out_b     (o_out_b)
    );

endmodule

// ----- hdl/shlae_chk.sv -----
// port-level checker for the light accumulator, bound to the top level
module shlae_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  logic [1:0]                         i_cmd,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [shlae_pkg::OUT_W-1:0] o_out_r,
    input  logic signed [shlae_pkg::OUT_W-1:0] o_out_g,
    input  logic signed [shlae_pkg::OUT_W-1:0] o_out_b
);
    import shlae_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_r) && $stable(o_out_g) && $stable(o_out_b))
        else $error("stalled result changed or dropped");

    a_clear_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_cmd == CMD_CLEAR |=> !o_in_stall)
        else $error("clear request held off the next request");

    a_work_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_cmd == CMD_ADD || i_cmd == CMD_SAMPLE) |=> o_in_stall)
        else $error("input taken while a request is in progress");

    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_cmd == CMD_ADD && !o_out_valid |=> !o_out_valid)
        else $error("add request produced a result");

endmodule

bind sh_light_accumulate_evaluate shlae_chk u_chk (.*);
